[rtl/mmlp_pkg.sv]
// ----------------------------------------------------------------------------
// mmlp_pkg
// Types, character codes and helpers shared by the memory-map line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mmlp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_W    = 8'h77;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_S    = 8'h73;

  localparam logic [1:0] FIELD_DEV   = 2'd0;
  localparam logic [1:0] FIELD_INODE = 2'd1;
  localparam logic [1:0] FIELD_PATH  = 2'd2;

  localparam logic [4:0] PERM_R = 5'b00001;
  localparam logic [4:0] PERM_W = 5'b00010;
  localparam logic [4:0] PERM_X = 5'b00100;
  localparam logic [4:0] PERM_P = 5'b01000;
  localparam logic [4:0] PERM_S = 5'b10000;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_REC  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    PH_START     = 5'd0,
    PH_START_TOK = 5'd1,
    PH_END_TOK   = 5'd2,
    PH_PERM0     = 5'd3,
    PH_PERM1     = 5'd4,
    PH_PERM2     = 5'd5,
    PH_PERM3     = 5'd6,
    PH_SKIP      = 5'd7,
    PH_OFFSET    = 5'd8,
    PH_DEV       = 5'd9,
    PH_INODE     = 5'd10,
    PH_SPACES    = 5'd11,
    PH_PATH      = 5'd12,
    PH_OPT_EOL   = 5'd13
  } phase_e;

  // results caused by one byte: one, or two when two is set
  typedef struct packed {
    logic        two;
    kind_e       k0;
    kind_e       k1;
    logic [1:0]  fld;
    logic [7:0]  chr;
    logic [63:0] rstart;
    logic [63:0] rend;
    logic [63:0] roffs;
    logic [4:0]  perm;
  } bundle_t;

  typedef struct packed {
    phase_e phase;
    logic   err;
  } front_status_t;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_text_delim(input logic [7:0] c);
    return is_eol(c) || (c == CH_NUL) || (c == CH_SP);
  endfunction

  function automatic logic is_hex_delim(input logic [7:0] c);
    return is_text_delim(c) || (c == CH_DASH);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61) begin
      t = c - 8'h57;
    end else begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

[rtl/mmlp_front.sv]
// ----------------------------------------------------------------------------
// mmlp_front
// Line parser: tracks the field of the line, accumulates hex tokens and
// packs the results of each accepted byte into one bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmlp_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   fire_i,
  input  wire logic [7:0]             text_byte_i,
  input  wire logic                   stream_end_i,
  output logic                        push_o,
  output mmlp_pkg::bundle_t           bundle_o,
  output mmlp_pkg::front_status_t     status_o
);
  import mmlp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [63:0] sa_q, sa_d, ea_q, ea_d, oa_q, oa_d;
  logic        hh_q, hh_d;
  logic [4:0]  pb_q, pb_d;
  logic        err_q, err_d;

  logic        path_c, do_start, txt, rec, err;
  logic [1:0]  fld;
  logic [63:0] snap_sa, snap_ea, snap_oa;
  logic [4:0]  snap_pb;
  logic [7:0]  c;

  assign c = text_byte_i;

  always_comb begin
    phase_d  = phase_q;
    sa_d     = sa_q;
    ea_d     = ea_q;
    oa_d     = oa_q;
    hh_d     = hh_q;
    pb_d     = pb_q;
    err_d    = err_q;
    path_c   = 1'b0;
    do_start = 1'b0;
    txt      = 1'b0;
    rec      = 1'b0;
    err      = 1'b0;
    fld      = FIELD_DEV;
    snap_sa  = sa_q;
    snap_ea  = ea_q;
    snap_oa  = oa_q;
    snap_pb  = pb_q;
    if (!err_q) begin
      unique case (phase_q)
        PH_START, PH_START_TOK: do_start = 1'b1;
        PH_END_TOK: begin
          if (is_hex_delim(c)) begin
            phase_d = PH_PERM0;
          end else if (hh_q || !is_hex(c)) begin
            hh_d = 1'b1;
          end else begin
            ea_d = {ea_q[59:0], hex_val(c)};
          end
        end
        PH_PERM0: begin
          if (c == CH_R) pb_d = pb_q | PERM_R;
          phase_d = PH_PERM1;
        end
        PH_PERM1: begin
          if (c == CH_W) pb_d = pb_q | PERM_W;
          phase_d = PH_PERM2;
        end
        PH_PERM2: begin
          if (c == CH_X) pb_d = pb_q | PERM_X;
          phase_d = PH_PERM3;
        end
        PH_PERM3: begin
          if (c == CH_P) begin
            pb_d = pb_q | PERM_P;
          end else if (c == CH_S) begin
            pb_d = pb_q | PERM_S;
          end
          phase_d = PH_SKIP;
        end
        PH_SKIP: begin
          hh_d    = 1'b0;
          phase_d = PH_OFFSET;
        end
        PH_OFFSET: begin
          if (is_hex_delim(c)) begin
            phase_d = PH_DEV;
          end else if (hh_q || !is_hex(c)) begin
            hh_d = 1'b1;
          end else begin
            oa_d = {oa_q[59:0], hex_val(c)};
          end
        end
        PH_DEV: begin
          if (is_text_delim(c)) begin
            phase_d = PH_INODE;
          end else begin
            txt = 1'b1;
            fld = FIELD_DEV;
          end
        end
        PH_INODE: begin
          if (c == CH_SP) begin
            phase_d = PH_SPACES;
          end else if (is_text_delim(c)) begin
            path_c = 1'b1;
          end else begin
            txt = 1'b1;
            fld = FIELD_INODE;
          end
        end
        PH_SPACES: begin
          if (c != CH_SP) path_c = 1'b1;
        end
        PH_PATH: path_c = 1'b1;
        PH_OPT_EOL: begin
          if (is_eol(c)) begin
            phase_d = PH_START;
          end else begin
            do_start = 1'b1;
          end
        end
        default: begin
          phase_d  = PH_START;
          sa_d     = '0;
          ea_d     = '0;
          oa_d     = '0;
          hh_d     = 1'b0;
          pb_d     = '0;
          do_start = 1'b1;
        end
      endcase

      if (path_c) begin
        phase_d = PH_PATH;
        if (is_eol(c) || (c == CH_NUL)) begin
          rec     = 1'b1;
          phase_d = is_eol(c) ? PH_OPT_EOL : PH_START;
          sa_d    = '0;
          ea_d    = '0;
          oa_d    = '0;
          hh_d    = 1'b0;
          pb_d    = '0;
          do_start = (c == CH_NUL);
        end else begin
          txt = 1'b1;
          fld = FIELD_PATH;
        end
      end

      if (do_start) begin
        if (c == CH_DASH) begin
          hh_d    = 1'b0;
          phase_d = PH_END_TOK;
        end else if (is_hex_delim(c)) begin
          err = 1'b1;
        end else begin
          if (hh_d || !is_hex(c)) begin
            hh_d = 1'b1;
          end else begin
            sa_d = {sa_d[59:0], hex_val(c)};
          end
          phase_d = PH_START_TOK;
        end
      end

      if (stream_end_i && !err) begin
        unique case (phase_d)
          PH_START_TOK, PH_END_TOK, PH_PERM0, PH_PERM1, PH_PERM2, PH_PERM3: err = 1'b1;
          PH_SKIP, PH_OFFSET, PH_DEV, PH_INODE, PH_SPACES, PH_PATH: begin
            rec     = 1'b1;
            snap_sa = sa_d;
            snap_ea = ea_d;
            snap_oa = oa_d;
            snap_pb = pb_d;
          end
          default: ;
        endcase
      end
      if (err) err_d = 1'b1;
    end

    if (stream_end_i) begin
      phase_d = PH_START;
      sa_d    = '0;
      ea_d    = '0;
      oa_d    = '0;
      hh_d    = 1'b0;
      pb_d    = '0;
      err_d   = 1'b0;
    end
  end

  always_comb begin
    bundle_o.two    = (txt && (rec || err)) || (rec && err);
    bundle_o.k0     = txt ? KIND_TEXT : (rec ? KIND_REC : KIND_ERR);
    bundle_o.k1     = (txt && rec) ? KIND_REC : KIND_ERR;
    bundle_o.fld    = fld;
    bundle_o.chr    = c;
    bundle_o.rstart = snap_sa;
    bundle_o.rend   = snap_ea;
    bundle_o.roffs  = snap_oa;
    bundle_o.perm   = snap_pb;
  end

  assign push_o          = fire_i && (txt || rec || err);
  assign status_o.phase  = phase_q;
  assign status_o.err    = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      sa_q    <= '0;
      ea_q    <= '0;
      oa_q    <= '0;
      hh_q    <= 1'b0;
      pb_q    <= '0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      sa_q    <= sa_d;
      ea_q    <= ea_d;
      oa_q    <= oa_d;
      hh_q    <= hh_d;
      pb_q    <= pb_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

[rtl/mmlp_fifo.sv]
// ----------------------------------------------------------------------------
// mmlp_fifo
// Short queue of result bundles between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mmlp_fifo #(
  parameter int unsigned Depth = mmlp_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire mmlp_pkg::bundle_t  data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output mmlp_pkg::bundle_t       data_o
);
  import mmlp_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (do_pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mmlp_back.sv]
// ----------------------------------------------------------------------------
// mmlp_back
// Output stage: takes bundles from the queue, computes the region size and
// hands out the results of each bundle one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mmlp_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire mmlp_pkg::bundle_t  q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              kind_o,
  output logic [1:0]              text_field_o,
  output logic [7:0]              field_char_o,
  output logic [63:0]             region_start_o,
  output logic [63:0]             region_end_o,
  output logic [63:0]             region_size_o,
  output logic [63:0]             file_offset_o,
  output logic [4:0]              perm_flags_o,
  output logic                    run_last_o
);
  import mmlp_pkg::*;

  bundle_t     b_q;
  logic [63:0] size_q;
  logic        idx_q, vld_q;
  logic        last_item, load;
  kind_e       kind;

  assign last_item = idx_q || !b_q.two;
  assign load      = q_valid_i && (!vld_q || (out_ready_i && last_item));
  assign q_pop_o   = load;
  assign kind      = idx_q ? b_q.k1 : b_q.k0;

  always_ff @(posedge clk_i) begin
    if (load) begin
      b_q    <= q_data_i;
      size_q <= q_data_i.rend - q_data_i.rstart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
      idx_q <= 1'b0;
    end else if (vld_q && out_ready_i) begin
      if (!last_item) begin
        idx_q <= 1'b1;
      end else begin
        vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_o    = vld_q;
    kind_o         = kind;
    run_last_o     = last_item;
    text_field_o   = (kind == KIND_TEXT) ? b_q.fld : 2'd0;
    field_char_o   = (kind == KIND_TEXT) ? b_q.chr : 8'd0;
    region_start_o = (kind == KIND_REC) ? b_q.rstart : 64'd0;
    region_end_o   = (kind == KIND_REC) ? b_q.rend : 64'd0;
    region_size_o  = (kind == KIND_REC) ? size_q : 64'd0;
    file_offset_o  = (kind == KIND_REC) ? b_q.roffs : 64'd0;
    perm_flags_o   = (kind == KIND_REC) ? b_q.perm : 5'd0;
  end

endmodule

`default_nettype wire

[rtl/memory_map_line_parser.sv]
// ----------------------------------------------------------------------------
// memory_map_line_parser
// Byte-serial parser for memory-map text lines.
//
// Input channel (in_valid_i/in_ready_o): one text byte per word, with
// stream_end_i marking the final byte. Output channel (out_valid_o/
// out_ready_i): one result per word - a field text byte, a completed
// record or a format error; run_last_o flags the last result of a byte.
// The parser takes one byte per cycle while in_ready_o is high; each byte
// updates its phase and shift-accumulates hex digits in that cycle. Its
// results are queued (QueueDepth bundles) and loaded from the queue into
// the output register. The output side moves one result per cycle while
// out_ready_i is high; a byte with two results takes two output words.
// A stalled receiver holds the output word; bytes keep flowing in until
// the queue is full, then in_ready_o drops.
// Reset clears the line state, the error flag, the queue and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_map_line_parser #(
  parameter int unsigned QueueDepth = mmlp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        stream_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [1:0]       text_field_o,
  output logic [7:0]       field_char_o,
  output logic [63:0]      region_start_o,
  output logic [63:0]      region_end_o,
  output logic [63:0]      region_size_o,
  output logic [63:0]      file_offset_o,
  output logic [4:0]       perm_flags_o,
  output logic             run_last_o
);
  import mmlp_pkg::*;

  logic          fire, push, full, q_valid, q_pop;
  bundle_t       push_data, q_data;
  front_status_t fstat;

  assign in_ready_o = !full;
  assign fire       = in_valid_i && in_ready_o;

  mmlp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .text_byte_i  (text_byte_i),
    .stream_end_i (stream_end_i),
    .push_o       (push),
    .bundle_o     (push_data),
    .status_o     (fstat)
  );

  mmlp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  mmlp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .text_field_o   (text_field_o),
    .field_char_o   (field_char_o),
    .region_start_o (region_start_o),
    .region_end_o   (region_end_o),
    .region_size_o  (region_size_o),
    .file_offset_o  (file_offset_o),
    .perm_flags_o   (perm_flags_o),
    .run_last_o     (run_last_o)
  );

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && stream_end_i) |=> (fstat.phase == PH_START && !fstat.err))
    else $error("stream end did not clear parser state");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_ERR) |-> run_last_o)
    else $error("format error not last result of its byte");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !run_last_o) |=> out_valid_o)
    else $error("second result of a byte missing");

endmodule

`default_nettype wire
